// ===== rtl/core/nfcp_pkg.sv =====
// ---------------------------------------------------------------------------
// NFC response frame parser package
// Shared item types, status and opcode values, register indexes and the
// byte reversal helper.
// ---------------------------------------------------------------------------
package nfcp_pkg;

   // Request opcodes
   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   // Frame status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_NO_SPACE = 2'd2
   } status_type;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_REVERSE  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREAMBLE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_FIRST  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SECOND = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TO_HOST_TFI  = 3'd4;

   // Register reset values
   localparam logic       RST_BIT_REVERSE  = 1'b1;
   localparam logic [7:0] RST_PREAMBLE     = 8'h00;
   localparam logic [7:0] RST_START_FIRST  = 8'h00;
   localparam logic [7:0] RST_START_SECOND = 8'hFF;
   localparam logic [7:0] RST_TO_HOST_TFI  = 8'hD5;

   // Frame overhead covered by LEN besides the payload (TFI and response code)
   localparam logic [7:0] LEN_OVERHEAD = 8'd2;

   typedef struct packed {
      logic       bit_reverse_enable;
      logic [7:0] preamble_value;
      logic [7:0] start_code_first;
      logic [7:0] start_code_second;
      logic [7:0] to_host_identifier;
   } cfg_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic [7:0] command_code;
      logic [7:0] capacity;
   } req_item_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic [7:0] data_index;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] payload_length;
   } rsp_item_type;

   // Reverse the bit order of one byte
   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/nfcp_if.sv =====
// ---------------------------------------------------------------------------
// NFC response frame parser channel interfaces
// Valid/ready channels for parse requests and for parser responses.
// ---------------------------------------------------------------------------
interface nfcp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   logic [7:0] command_code;
   logic [7:0] capacity;

   modport source (output valid, output op, output rx_byte, output command_code,
                   output capacity, input ready);
   modport sink   (input valid, input op, input rx_byte, input command_code,
                   input capacity, output ready);
endinterface

interface nfcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       data_valid;
   logic [7:0] data_byte;
   logic [7:0] data_index;
   logic       done_res;
   logic [1:0] status;
   logic [7:0] payload_length;

   modport source (output valid, output data_valid, output data_byte,
                   output data_index, output done_res, output status,
                   output payload_length, input ready);
   modport sink   (input valid, input data_valid, input data_byte,
                   input data_index, input done_res, input status,
                   input payload_length, output ready);
endinterface

// ===== rtl/core/nfcp_parser.sv =====
// ---------------------------------------------------------------------------
// NFC response frame parser state machine
// Walks one response frame a byte at a time, checks header and checksums,
// and produces at most one response per accepted request.
// ---------------------------------------------------------------------------
module nfcp_parser
   import nfcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  req_item_type req,
   output logic         res_push,
   output rsp_item_type res
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_PRE, PH_SC1, PH_SC2, PH_LEN, PH_LCS,
      PH_TFI, PH_PD0, PH_DATA, PH_DCS, PH_POST
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] expected_ff, expected_in;
   logic [7:0] room_ff, room_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic       skipping_ff, skipping_in;

   logic [7:0] b;
   logic [7:0] count_next;
   logic       fin;
   status_type fin_status;

   assign b          = cfg.bit_reverse_enable ? rev8(req.rx_byte) : req.rx_byte;
   assign count_next = count_ff + 8'd1;

   // Next state and response for the request being accepted
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      room_in     = room_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      skipping_in = skipping_ff;
      fin         = 1'b0;
      fin_status  = STATUS_INVALID;
      res_push    = 1'b0;
      res         = '0;

      if (req.op == OP_START) begin
         expected_in = req.command_code + 8'd1;
         room_in     = req.capacity;
         length_in   = '0;
         sum_in      = '0;
         count_in    = '0;
         skipping_in = 1'b0;
         phase_in    = PH_PRE;
      end else begin
         case (phase_ff)
            PH_PRE: begin
               if (b != cfg.preamble_value) fin = 1'b1;
               else phase_in = PH_SC1;
            end
            PH_SC1: begin
               if (b != cfg.start_code_first) fin = 1'b1;
               else phase_in = PH_SC2;
            end
            PH_SC2: begin
               if (b != cfg.start_code_second) fin = 1'b1;
               else phase_in = PH_LEN;
            end
            PH_LEN: begin
               length_in = b;
               phase_in  = PH_LCS;
            end
            PH_LCS: begin
               // LEN + LCS must wrap to zero; short LEN is rejected too
               if ((length_ff + b) != 8'd0 || length_ff < LEN_OVERHEAD) begin
                  fin = 1'b1;
               end else begin
                  length_in = length_ff - LEN_OVERHEAD;
                  phase_in  = PH_TFI;
               end
            end
            PH_TFI: begin
               if (b != cfg.to_host_identifier) begin
                  fin = 1'b1;
               end else begin
                  sum_in   = b;
                  phase_in = PH_PD0;
               end
            end
            PH_PD0: begin
               if (b != expected_ff) begin
                  fin = 1'b1;
               end else begin
                  sum_in      = sum_ff + b;
                  count_in    = '0;
                  skipping_in = (length_ff > room_ff);
                  phase_in    = (length_ff == 8'd0) ? PH_DCS : PH_DATA;
               end
            end
            PH_DATA: begin
               count_in = count_next;
               if (count_next >= length_ff) phase_in = PH_DCS;
               if (!skipping_ff) begin
                  sum_in         = sum_ff + b;
                  res_push       = 1'b1;
                  res.data_valid = 1'b1;
                  res.data_byte  = b;
                  res.data_index = count_ff;
               end
            end
            PH_DCS: begin
               if (!skipping_ff && (sum_ff + b) != 8'd0) fin = 1'b1;
               else phase_in = PH_POST;
            end
            PH_POST: begin
               fin        = 1'b1;
               fin_status = skipping_ff ? STATUS_NO_SPACE : STATUS_OK;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase

         // Final response of the frame
         if (fin) begin
            phase_in           = PH_IDLE;
            skipping_in        = 1'b0;
            res_push           = 1'b1;
            res.done_res       = 1'b1;
            res.status         = fin_status;
            res.payload_length = (fin_status == STATUS_OK) ? length_ff : 8'd0;
         end
      end

      if (!accept) begin
         res_push = 1'b0;
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         expected_ff <= '0;
         room_ff     <= '0;
         length_ff   <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         skipping_ff <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         expected_ff <= expected_in;
         room_ff     <= room_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         skipping_ff <= skipping_in;
      end
   end

endmodule

// ===== rtl/core/nfcp_rsp_buf.sv =====
// ---------------------------------------------------------------------------
// NFC response frame parser response buffer
// Output register with a skid stage, so requests keep flowing while a
// response waits to be taken.
// ---------------------------------------------------------------------------
module nfcp_rsp_buf
   import nfcp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_data,
   output logic         can_accept,
   nfcp_rsp_if.source   rsp_chan
);

   logic         out_valid_ff;
   rsp_item_type out_data_ff;
   logic         skid_valid_ff;
   rsp_item_type skid_data_ff;
   logic         out_free;

   assign out_free   = !out_valid_ff || rsp_chan.ready;
   assign can_accept = !skid_valid_ff;

   // Control: output register refills from skid first
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.data_valid     = out_data_ff.data_valid;
   assign rsp_chan.data_byte      = out_data_ff.data_byte;
   assign rsp_chan.data_index     = out_data_ff.data_index;
   assign rsp_chan.done_res       = out_data_ff.done_res;
   assign rsp_chan.status         = out_data_ff.status;
   assign rsp_chan.payload_length = out_data_ff.payload_length;

endmodule

// ===== rtl/core/nfc_response_frame_parser.sv =====
// Responses are registered: output register, or skid entry while rsp stalls.
// One request per cycle while skid is empty; frame state updated in a single pass.
// A two-entry output (register plus skid) lets requests continue while rsp stalls.
// Reset is synchronous, active high: parser idle, registers at default values.
// ---------------------------------------------------------------------------
// NFC response frame parser top level
// Configuration registers, frame parser and response buffer.
// ---------------------------------------------------------------------------
module nfc_response_frame_parser
   import nfcp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   nfcp_req_if.sink               req_chan,
   nfcp_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_write_data
);

   cfg_type      cfg_ff;
   req_item_type req;
   rsp_item_type res;
   logic         res_push;
   logic         can_accept;
   logic         accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_reverse_enable <= RST_BIT_REVERSE;
         cfg_ff.preamble_value     <= RST_PREAMBLE;
         cfg_ff.start_code_first   <= RST_START_FIRST;
         cfg_ff.start_code_second  <= RST_START_SECOND;
         cfg_ff.to_host_identifier <= RST_TO_HOST_TFI;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BIT_REVERSE:  cfg_ff.bit_reverse_enable <= csr_write_data[0];
            CSR_PREAMBLE:     cfg_ff.preamble_value     <= csr_write_data;
            CSR_START_FIRST:  cfg_ff.start_code_first   <= csr_write_data;
            CSR_START_SECOND: cfg_ff.start_code_second  <= csr_write_data;
            CSR_TO_HOST_TFI:  cfg_ff.to_host_identifier <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Request handshake
   assign req_chan.ready   = can_accept;
   assign accept           = req_chan.valid && can_accept;
   assign req.op           = req_chan.op;
   assign req.rx_byte      = req_chan.rx_byte;
   assign req.command_code = req_chan.command_code;
   assign req.capacity     = req_chan.capacity;

   nfcp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .req      (req),
      .res_push (res_push),
      .res      (res)
   );

   nfcp_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_push),
      .push_data  (res),
      .can_accept (can_accept),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/core/nfcp_checker.sv =====
// ---------------------------------------------------------------------------
// NFC response frame parser port checker
// Watches the top level ports for handshake and response consistency.
// ---------------------------------------------------------------------------
module nfcp_checker
   import nfcp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_data_valid,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_data_index,
   input logic       rsp_done_res,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_payload_length
);

   // A stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_data_index) && $stable(rsp_status))
      else $error("stalled response changed");

   // Request side only stalls when a response is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // Nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A response is either a payload byte or a frame end, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data_valid != rsp_done_res)
         && (!rsp_data_valid || rsp_status == STATUS_OK))
      else $error("malformed response kind");

   // Failed frames report zero length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_status != STATUS_OK |-> rsp_payload_length == 8'd0)
      else $error("nonzero length on failed frame");

endmodule

bind nfc_response_frame_parser nfcp_checker u_nfcp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_data_valid     (rsp_chan.data_valid),
   .rsp_data_byte      (rsp_chan.data_byte),
   .rsp_data_index     (rsp_chan.data_index),
   .rsp_done_res       (rsp_chan.done_res),
   .rsp_status         (rsp_chan.status),
   .rsp_payload_length (rsp_chan.payload_length)
);
